// File: rtl/ocu_pkg.sv
// ----------------------------------------------------------------------------
// ocu_pkg
// Shared widths, reset values, register indexes, sideband type and the
// elaboration-time helpers that build the exp2 constant table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ocu_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned ML_W          = 31;
    localparam int unsigned DAMP_W        = 18;
    localparam int unsigned DUAL_W        = 31;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 31;

    localparam int unsigned DEN_W         = DUAL_W + DATA_W;      // 63
    localparam int unsigned DIV_BITS      = 2;                    // quotient bits per stage
    localparam int unsigned DIV_STAGES    = DATA_W / DIV_BITS;    // 16

    localparam int unsigned LOG_FRAC_BITS = 24;
    localparam int unsigned LOG_W         = 5 + LOG_FRAC_BITS;    // signed Q5.24
    localparam int unsigned PROD_W        = DAMP_W + LOG_W;       // 47
    localparam int unsigned EXPN_W        = PROD_W - 40;          // integer part of exponent
    localparam int unsigned RAW_W         = 2 * DATA_W;
    localparam int unsigned SHIFT_W       = RAW_W + DATA_W;
    localparam int unsigned VMAG_W        = 41;
    localparam int unsigned VAL_W         = VMAG_W + 1;

    localparam logic [VMAG_W-1:0] VMAG_SAT  = {1'b1, {(VMAG_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] Q_LIM_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] Q_LIM_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] P_ONE     = {1'b1, {(DATA_W-1){1'b0}}};   // 1.0 in Q1.31

    localparam logic [ML_W-1:0]   ML_RESET   = 31'd13107;
    localparam logic [DAMP_W-1:0] DAMP_RESET = 18'd32768;
    localparam logic [DUAL_W-1:0] DUAL_RESET = 31'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOVE_LIMIT = 2'd0,
        CFG_DAMPING    = 2'd1,
        CFG_DUAL       = 2'd2
    } t_cfg_idx;

    // Per-item values that ride along the pipeline
    typedef struct packed {
        logic signed [DATA_W-1:0] cur_density;
        logic signed [DATA_W-1:0] lower_limit;
        logic signed [DATA_W-1:0] upper_limit;
        logic                     neg;
        logic                     sat;
        logic                     qz;
    } t_side;

    // Floor square root, used only at elaboration
    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x   = val;
        res = '0;
        b   = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b > x) b = b >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (b != '0) begin
                if (x >= res + b) begin
                    x   = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-idx) in Q1.31 by repeated floor square roots of 2.0
    function automatic logic [31:0] exp_rom_val(input int idx);
        logic [63:0] r;
        r = 64'd1 << 32;
        for (int k = 1; k <= LOG_FRAC_BITS; k++) begin
            if (k <= idx) r = isqrt64(r << 31);
        end
        return r[31:0];
    endfunction

endpackage

// File: rtl/optimality_criteria_update.sv
// Throughput: one element per cycle; the fully pipelined divider, 24-stage log2 squaring
// chain and 24-stage exp2 product chain each take one element every cycle unless stalled.
// A two-entry output buffer lets the pipeline run while a result waits; input stalls
// only when that buffer is full.
// Reset (synchronous, active low) empties the pipeline and buffer and restores registers.
// ----------------------------------------------------------------------------
// optimality_criteria_update
// Per-element optimality-criteria update in Q16.16: quotient, damped power,
// move-limit and bound clamps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module optimality_criteria_update (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic        [ocu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [ocu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [ocu_pkg::DATA_W-1:0]     i_cur_density,
    input  logic signed [ocu_pkg::DATA_W-1:0]     i_objective_gradient,
    input  logic signed [ocu_pkg::DATA_W-1:0]     i_constraint_gradient,
    input  logic signed [ocu_pkg::DATA_W-1:0]     i_lower_limit,
    input  logic signed [ocu_pkg::DATA_W-1:0]     i_upper_limit,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [ocu_pkg::DATA_W-1:0]     o_upd_density,
    output logic                                  o_quotient_saturated
);
    import ocu_pkg::*;

    // Configuration registers
    logic [ML_W-1:0]   r_move_limit;
    logic [DAMP_W-1:0] r_damping;
    logic [DUAL_W-1:0] r_dual;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_limit <= ML_RESET;
            r_damping    <= DAMP_RESET;
            r_dual       <= DUAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MOVE_LIMIT: r_move_limit <= i_cfg_data[ML_W-1:0];
                CFG_DAMPING:    r_damping    <= i_cfg_data[DAMP_W-1:0];
                CFG_DUAL:       r_dual       <= i_cfg_data[DUAL_W-1:0];
                default:        ;
            endcase
        end
    end

    // Pipeline advances unless the output buffer is full
    logic [1:0] r_cnt;
    logic       w_en;

    assign w_en       = (r_cnt != 2'd2);
    assign o_in_stall = !w_en;

    // Quotient
    logic              w_div_vld;
    logic [DATA_W-1:0] w_qm;
    t_side             w_div_side;

    ocu_div u_div (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_en                  (w_en),
        .i_vld                 (i_in_valid),
        .i_cur_density         (i_cur_density),
        .i_objective_gradient  (i_objective_gradient),
        .i_constraint_gradient (i_constraint_gradient),
        .i_lower_limit         (i_lower_limit),
        .i_upper_limit         (i_upper_limit),
        .i_dual                (r_dual),
        .o_vld                 (w_div_vld),
        .o_qm                  (w_qm),
        .o_side                (w_div_side)
    );

    // log2 of the quotient magnitude
    logic                    w_log_vld;
    logic signed [LOG_W-1:0] w_log;
    t_side                   w_log_side;

    ocu_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_div_vld),
        .i_qm    (w_qm),
        .i_side  (w_div_side),
        .o_vld   (w_log_vld),
        .o_log   (w_log),
        .o_side  (w_log_side)
    );

    // Damped power times |old|
    logic              w_exp_vld;
    logic [VMAG_W-1:0] w_vmag;
    t_side             w_exp_side;
    t_side             w_exp_side_in;

    assign w_exp_side_in = w_log_side;

    ocu_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_log_vld),
        .i_log   (w_log),
        .i_side  (w_exp_side_in),
        .i_damp  (r_damping),
        .o_vld   (w_exp_vld),
        .o_vmag  (w_vmag),
        .o_side  (w_exp_side)
    );

    // Clamp stage 0: apply sign, form old +/- move
    logic                    r_c0_vld;
    logic signed [VAL_W-1:0] r_c0_v;
    logic signed [VAL_W-1:0] r_c0_hi;
    logic signed [VAL_W-1:0] r_c0_lo;
    t_side                   r_c0_side;
    logic signed [VAL_W-1:0] n_c0_mag;
    logic signed [VAL_W-1:0] n_c0_old;
    logic signed [VAL_W-1:0] n_c0_ml;

    assign n_c0_mag = $signed({1'b0, w_vmag});
    assign n_c0_old = $signed({{(VAL_W-DATA_W){w_exp_side.cur_density[DATA_W-1]}},
                               w_exp_side.cur_density});
    assign n_c0_ml  = $signed({{(VAL_W-ML_W){1'b0}}, r_move_limit});

    // Clamp stage 1: min with old + move, then with upper
    logic                    r_c1_vld;
    logic signed [VAL_W-1:0] r_c1_v;
    logic signed [VAL_W-1:0] r_c1_lo;
    t_side                   r_c1_side;
    logic signed [VAL_W-1:0] n_c1_a;
    logic signed [VAL_W-1:0] n_c1_b;
    logic signed [VAL_W-1:0] n_c1_up;

    // Clamp stage 2: max with old - move, then with lower
    logic                    r_c2_vld;
    logic signed [DATA_W-1:0] r_c2_v;
    logic                    r_c2_sat;
    logic signed [VAL_W-1:0] n_c2_a;
    logic signed [VAL_W-1:0] n_c2_b;
    logic signed [VAL_W-1:0] n_c2_low;

    always_comb begin
        n_c1_up  = $signed({{(VAL_W-DATA_W){r_c0_side.upper_limit[DATA_W-1]}},
                            r_c0_side.upper_limit});
        n_c1_a   = (r_c0_v > r_c0_hi) ? r_c0_hi : r_c0_v;
        n_c1_b   = (n_c1_a > n_c1_up) ? n_c1_up : n_c1_a;
        n_c2_low = $signed({{(VAL_W-DATA_W){r_c1_side.lower_limit[DATA_W-1]}},
                            r_c1_side.lower_limit});
        n_c2_a   = (r_c1_v < r_c1_lo) ? r_c1_lo : r_c1_v;
        n_c2_b   = (n_c2_a < n_c2_low) ? n_c2_low : n_c2_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0_vld <= 1'b0;
            r_c1_vld <= 1'b0;
            r_c2_vld <= 1'b0;
        end else if (w_en) begin
            r_c0_vld <= w_exp_vld;
            r_c1_vld <= r_c0_vld;
            r_c2_vld <= r_c1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c0_v    <= (w_exp_side.cur_density[DATA_W-1] != w_exp_side.neg) ?
                         -n_c0_mag : n_c0_mag;
            r_c0_hi   <= n_c0_old + n_c0_ml;
            r_c0_lo   <= n_c0_old - n_c0_ml;
            r_c0_side <= w_exp_side;
            r_c1_v    <= n_c1_b;
            r_c1_lo   <= r_c0_lo;
            r_c1_side <= r_c0_side;
            r_c2_v    <= n_c2_b[DATA_W-1:0];
            r_c2_sat  <= r_c1_side.sat;
        end
    end

    // Output buffer: two entries, transfer out from the read pointer
    logic signed [DATA_W-1:0] r_buf_v   [0:1];
    logic                     r_buf_sat [0:1];
    logic                     r_wp;
    logic                     r_rp;
    logic                     w_push;
    logic                     w_pop;

    assign w_push = w_en && r_c2_vld;
    assign w_pop  = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf_v[r_wp]   <= r_c2_v;
            r_buf_sat[r_wp] <= r_c2_sat;
        end
    end

    assign o_out_valid          = (r_cnt != 2'd0);
    assign o_upd_density        = r_buf_v[r_rp];
    assign o_quotient_saturated = r_buf_sat[r_rp];

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |-> (r_cnt != 2'd2))
        else $error("push into a full output buffer");

    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_c2_vld) && $stable(r_c2_v)))
        else $error("pipeline moved while frozen");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("buffer pointers disagree with count");
`endif

endmodule

// File: rtl/ocu_div.sv
// ----------------------------------------------------------------------------
// ocu_div
// Quotient front end: magnitudes, divisor product, radix-2 restoring
// division two bits per stage, then sign and saturation of the quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ocu_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic signed [ocu_pkg::DATA_W-1:0] i_cur_density,
    input  logic signed [ocu_pkg::DATA_W-1:0] i_objective_gradient,
    input  logic signed [ocu_pkg::DATA_W-1:0] i_constraint_gradient,
    input  logic signed [ocu_pkg::DATA_W-1:0] i_lower_limit,
    input  logic signed [ocu_pkg::DATA_W-1:0] i_upper_limit,
    input  logic        [ocu_pkg::DUAL_W-1:0] i_dual,
    output logic                              o_vld,
    output logic        [ocu_pkg::DATA_W-1:0] o_qm,
    output ocu_pkg::t_side                    o_side
);
    import ocu_pkg::*;

    // Stage 0: magnitudes and quotient sign
    logic              n0_den0;
    logic              n0_neg;
    logic [DATA_W-1:0] n0_gm;
    logic [DATA_W-1:0] n0_cm;
    logic              r0_vld;
    logic              r0_neg;
    logic [DATA_W-1:0] r0_gm;
    logic [DATA_W-1:0] r0_cm;
    t_side             r0_side;

    assign n0_gm   = i_objective_gradient[DATA_W-1] ?
                     (~i_objective_gradient + DATA_W'(1)) : i_objective_gradient;
    assign n0_cm   = i_constraint_gradient[DATA_W-1] ?
                     (~i_constraint_gradient + DATA_W'(1)) : i_constraint_gradient;
    assign n0_den0 = (i_dual == '0) || (i_constraint_gradient == '0);
    assign n0_neg  = n0_den0 ?
        (!i_objective_gradient[DATA_W-1] && (i_objective_gradient != '0)) :
        ((i_objective_gradient != '0) &&
         (i_objective_gradient[DATA_W-1] == i_constraint_gradient[DATA_W-1]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_gm               <= n0_gm;
            r0_cm               <= n0_cm;
            r0_neg              <= n0_neg;
            r0_side.cur_density <= i_cur_density;
            r0_side.lower_limit <= i_lower_limit;
            r0_side.upper_limit <= i_upper_limit;
            r0_side.neg         <= 1'b0;
            r0_side.sat         <= 1'b0;
            r0_side.qz          <= 1'b0;
        end
    end

    // Stage 1: divisor = dual * |c|
    logic              r1_vld;
    logic              r1_neg;
    logic [DATA_W-1:0] r1_gm;
    logic [DEN_W-1:0]  r1_den;
    t_side             r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_den  <= DEN_W'(i_dual) * DEN_W'(r0_cm);
            r1_gm   <= r0_gm;
            r1_neg  <= r0_neg;
            r1_side <= r0_side;
        end
    end

    // Stage 2: overflow when the quotient needs more than 32 bits
    logic              r_vld  [0:DIV_STAGES];
    logic [DEN_W-1:0]  r_rem  [0:DIV_STAGES];
    logic [DATA_W-1:0] r_quo  [0:DIV_STAGES];
    logic [DEN_W-1:0]  r_den  [0:DIV_STAGES];
    logic              r_ovf  [0:DIV_STAGES];
    logic              r_neg  [0:DIV_STAGES];
    t_side             r_side [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= DEN_W'(r1_gm);
            r_quo[0]  <= '0;
            r_den[0]  <= r1_den;
            r_ovf[0]  <= DEN_W'(r1_gm) >= r1_den;
            r_neg[0]  <= r1_neg;
            r_side[0] <= r1_side;
        end
    end

    // Division stages: each resolves DIV_BITS quotient bits
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        logic [DEN_W-1:0]  n_rem;
        logic [DATA_W-1:0] n_quo;

        always_comb begin
            logic [DEN_W:0]    t;
            logic [DEN_W-1:0]  rem;
            logic [DATA_W-1:0] quo;
            rem = r_rem[s];
            quo = r_quo[s];
            for (int b = 0; b < DIV_BITS; b++) begin
                t = {rem, 1'b0};
                if (t >= {1'b0, r_den[s]}) begin
                    rem = DEN_W'(t - {1'b0, r_den[s]});
                    quo = {quo[DATA_W-2:0], 1'b1};
                end else begin
                    rem = t[DEN_W-1:0];
                    quo = {quo[DATA_W-2:0], 1'b0};
                end
            end
            n_rem = rem;
            n_quo = quo;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= n_rem;
                r_quo[s+1]  <= n_quo;
                r_den[s+1]  <= r_den[s];
                r_ovf[s+1]  <= r_ovf[s];
                r_neg[s+1]  <= r_neg[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    // Final stage: saturate to the signed limit, zero quotient counts as positive
    logic [DATA_W-1:0] n_lim;
    logic              n_sat;
    logic [DATA_W-1:0] n_qm;
    logic              n_qz;
    t_side             n_side;

    always_comb begin
        n_lim         = r_neg[DIV_STAGES] ? Q_LIM_NEG : Q_LIM_POS;
        n_sat         = r_ovf[DIV_STAGES] || (r_quo[DIV_STAGES] > n_lim);
        n_qm          = n_sat ? n_lim : r_quo[DIV_STAGES];
        n_qz          = (n_qm == '0);
        n_side        = r_side[DIV_STAGES];
        n_side.sat    = n_sat;
        n_side.qz     = n_qz;
        n_side.neg    = r_neg[DIV_STAGES] && !n_qz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r_vld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_qm   <= n_qm;
            o_side <= n_side;
        end
    end

endmodule

// File: rtl/ocu_log2.sv
// ----------------------------------------------------------------------------
// ocu_log2
// log2 of the quotient magnitude: leading-one search, normalize to Q1.31,
// then one squaring stage per fraction bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ocu_log2 (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_vld,
    input  logic        [ocu_pkg::DATA_W-1:0]      i_qm,
    input  ocu_pkg::t_side                         i_side,
    output logic                                   o_vld,
    output logic signed [ocu_pkg::LOG_W-1:0]       o_log,
    output ocu_pkg::t_side                         o_side
);
    import ocu_pkg::*;

    // Stage 0: position of the leading one
    logic [4:0]        n0_e;
    logic              r0_vld;
    logic [4:0]        r0_e;
    logic [DATA_W-1:0] r0_qm;
    t_side             r0_side;

    always_comb begin
        n0_e = '0;
        for (int k = 0; k < DATA_W; k++) begin
            if (i_qm[k]) n0_e = 5'(k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_e    <= n0_e;
            r0_qm   <= i_qm;
            r0_side <= i_side;
        end
    end

    // Stage 1: normalize the mantissa to [1, 2) in Q1.31
    logic              r_vld  [0:LOG_FRAC_BITS];
    logic [DATA_W-1:0] r_m    [0:LOG_FRAC_BITS];
    logic [LOG_FRAC_BITS-1:0] r_frac [0:LOG_FRAC_BITS];
    logic [4:0]        r_e    [0:LOG_FRAC_BITS];
    t_side             r_side [0:LOG_FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]    <= r0_qm << (5'd31 - r0_e);
            r_frac[0] <= '0;
            r_e[0]    <= r0_e;
            r_side[0] <= r0_side;
        end
    end

    // Squaring stages: a square at or above 2.0 yields a one bit and halves
    for (genvar s = 0; s < LOG_FRAC_BITS; s++) begin : g_sq
        logic [RAW_W-1:0]  n_sq;
        logic [DATA_W:0]   n_t;
        logic [DATA_W-1:0] n_m;

        assign n_sq = RAW_W'(r_m[s]) * RAW_W'(r_m[s]);
        assign n_t  = n_sq[RAW_W-1:DATA_W-1];
        assign n_m  = n_t[DATA_W] ? n_t[DATA_W:1] : n_t[DATA_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[s+1]    <= n_m;
                r_frac[s+1] <= {r_frac[s][LOG_FRAC_BITS-2:0], n_t[DATA_W]};
                r_e[s+1]    <= r_e[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    // Integer part e - 16 in five bits is the leading one position with its MSB flipped
    assign o_vld  = r_vld[LOG_FRAC_BITS];
    assign o_log  = {~r_e[LOG_FRAC_BITS][4], r_e[LOG_FRAC_BITS][3:0], r_frac[LOG_FRAC_BITS]};
    assign o_side = r_side[LOG_FRAC_BITS];

endmodule

// File: rtl/ocu_exp.sv
// ----------------------------------------------------------------------------
// ocu_exp
// Power stage: exponent = damping * log2|q|, 2^frac as a product of table
// constants one per stage, scale |old| and shift by the integer exponent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ocu_exp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic signed [ocu_pkg::LOG_W-1:0]  i_log,
    input  ocu_pkg::t_side                    i_side,
    input  logic        [ocu_pkg::DAMP_W-1:0] i_damp,
    output logic                              o_vld,
    output logic        [ocu_pkg::VMAG_W-1:0] o_vmag,
    output ocu_pkg::t_side                    o_side
);
    import ocu_pkg::*;

    // Stage 0: exponent product, split into integer and 24 fraction bits
    logic signed [PROD_W-1:0] n0_prod;

    assign n0_prod = $signed({{(PROD_W-DAMP_W){1'b0}}, i_damp}) *
                     $signed({{(PROD_W-LOG_W){i_log[LOG_W-1]}}, i_log});

    logic                     r_vld  [0:LOG_FRAC_BITS];
    logic [DATA_W-1:0]        r_p    [0:LOG_FRAC_BITS];
    logic [LOG_FRAC_BITS-1:0] r_f    [0:LOG_FRAC_BITS];
    logic [EXPN_W-1:0]        r_n    [0:LOG_FRAC_BITS];
    t_side                    r_side [0:LOG_FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]    <= P_ONE;
            r_f[0]    <= n0_prod[39:16];
            r_n[0]    <= n0_prod[PROD_W-1:40];
            r_side[0] <= i_side;
        end
    end

    // Product stages: multiply by 2^(2^-i) where fraction bit i is set
    for (genvar gi = 1; gi <= LOG_FRAC_BITS; gi++) begin : g_pow
        localparam logic [DATA_W-1:0] K = exp_rom_val(gi);
        logic [RAW_W-1:0]  n_prod;
        logic [DATA_W-1:0] n_p;

        assign n_prod = RAW_W'(r_p[gi-1]) * RAW_W'(K);
        assign n_p    = r_f[gi-1][LOG_FRAC_BITS-gi] ? n_prod[RAW_W-2:DATA_W-1] : r_p[gi-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gi] <= 1'b0;
            end else if (i_en) begin
                r_vld[gi] <= r_vld[gi-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[gi]    <= n_p;
                r_f[gi]    <= r_f[gi-1];
                r_n[gi]    <= r_n[gi-1];
                r_side[gi] <= r_side[gi-1];
            end
        end
    end

    // Scale stage: raw = |old| * 2^frac
    logic [DATA_W-1:0] n_om;
    logic              rs_vld;
    logic [RAW_W-1:0]  rs_raw;
    logic [EXPN_W-1:0] rs_n;
    t_side             rs_side;

    assign n_om = r_side[LOG_FRAC_BITS].cur_density[DATA_W-1] ?
                  (~r_side[LOG_FRAC_BITS].cur_density + DATA_W'(1)) :
                  r_side[LOG_FRAC_BITS].cur_density;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rs_vld <= 1'b0;
        end else if (i_en) begin
            rs_vld <= r_vld[LOG_FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rs_raw  <= RAW_W'(n_om) * RAW_W'(r_p[LOG_FRAC_BITS]);
            rs_n    <= r_n[LOG_FRAC_BITS];
            rs_side <= r_side[LOG_FRAC_BITS];
        end
    end

    // Shift stage: apply 2^(n-31), left shift is exact in the wide word
    logic                   n_left;
    logic [EXPN_W-1:0]      n_lsh;
    logic [EXPN_W-1:0]      n_rsh;
    logic [SHIFT_W-1:0]     n_shifted;
    logic                   rh_vld;
    logic [SHIFT_W-1:0]     rh_shifted;
    t_side                  rh_side;

    always_comb begin
        n_left = ($signed(rs_n) >= $signed(EXPN_W'(31)));
        n_lsh  = rs_n - EXPN_W'(31);
        n_rsh  = EXPN_W'(31) - rs_n;
        if (n_left) begin
            n_shifted = SHIFT_W'(rs_raw) << n_lsh[5:0];
        end else if (n_rsh[EXPN_W-1]) begin
            n_shifted = '0;
        end else begin
            n_shifted = SHIFT_W'(rs_raw >> n_rsh[5:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rh_vld <= 1'b0;
        end else if (i_en) begin
            rh_vld <= rs_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rh_shifted <= n_shifted;
            rh_side    <= rs_side;
        end
    end

    // Final stage: saturate, and take the zero-quotient and zero-damping cases
    logic [VMAG_W-1:0] n_vcalc;
    logic [VMAG_W-1:0] n_om41;
    logic [VMAG_W-1:0] n_vmag;

    always_comb begin
        n_vcalc = (rh_shifted > SHIFT_W'(VMAG_SAT)) ? VMAG_SAT : rh_shifted[VMAG_W-1:0];
        n_om41  = {{(VMAG_W-DATA_W){1'b0}},
                   (rh_side.cur_density[DATA_W-1] ?
                    (~rh_side.cur_density + DATA_W'(1)) :
                    rh_side.cur_density)};
        if (rh_side.qz) begin
            n_vmag = (i_damp != '0) ? '0 : n_om41;
        end else if (i_damp == '0) begin
            n_vmag = n_om41;
        end else begin
            n_vmag = n_vcalc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= rh_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_vmag <= n_vmag;
            o_side <= rh_side;
        end
    end

endmodule
